>>> sv/rlsfe_pkg.sv
// ----------------------------------------------------------------------------
// rlsfe_pkg: shared types and constants of the LED strip frame encoder
// Item layouts of both channels, request/status/register codes, controller
// states and the symbol word packing helper.
// ----------------------------------------------------------------------------
package rlsfe_pkg;

  // Store geometry
  localparam int MAX_PIXELS = 1024;
  localparam int PIX_AW     = $clog2(MAX_PIXELS);      // store address bits
  localparam int PIX_CW     = $clog2(MAX_PIXELS + 1);  // counts up to MAX_PIXELS

  // Field widths
  localparam int TICK_W    = 15;
  localparam int COLOR_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 15;
  localparam int ROOM_W    = 10;

  // Symbols per encoded byte and the minimum room needed to emit them
  localparam int SYM_PER_BYTE = 8;
  localparam logic [ROOM_W-1:0] ROOM_MIN = ROOM_W'(SYM_PER_BYTE);
  localparam logic [3:0] CNT_BYTE  = 4'(SYM_PER_BYTE);
  localparam logic [3:0] CNT_LATCH = 4'd1;

  // Register reset values
  localparam logic [7:0]        GRID_WIDTH_RST  = 8'd8;
  localparam logic [7:0]        GRID_HEIGHT_RST = 8'd8;
  localparam logic [TICK_W-1:0] ZERO_HIGH_RST   = 15'd40;
  localparam logic [TICK_W-1:0] ZERO_LOW_RST    = 15'd85;
  localparam logic [TICK_W-1:0] ONE_HIGH_RST    = 15'd80;
  localparam logic [TICK_W-1:0] ONE_LOW_RST     = 15'd45;
  localparam logic [TICK_W-1:0] LATCH_RST       = 15'd250;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH       = 3'd6;

  // Request codes
  localparam logic [2:0] REQ_WRITE_XY  = 3'd0;
  localparam logic [2:0] REQ_READ_XY   = 3'd1;
  localparam logic [2:0] REQ_WRITE_IDX = 3'd2;
  localparam logic [2:0] REQ_READ_IDX  = 3'd3;
  localparam logic [2:0] REQ_FILL      = 3'd4;
  localparam logic [2:0] REQ_ENCODE    = 3'd5;

  // Status codes
  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_OUTSIDE = 2'd1;
  localparam logic [1:0] STS_NO_ROOM = 2'd2;

  // Byte lanes within a stored pixel (green, red, blue)
  localparam logic [1:0] LANE_GREEN = 2'd0;
  localparam logic [1:0] LANE_RED   = 2'd1;
  localparam logic [1:0] LANE_BLUE  = 2'd2;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [7:0]        col_x;
    logic [7:0]        row_y;
    logic [15:0]       linear_index;
    logic [7:0]        red_in;
    logic [7:0]        green_in;
    logic [7:0]        blue_in;
    logic              first_chunk;
    logic [ROOM_W-1:0] room;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [3:0]  symbol_count;
    logic [63:0] symbols_a;
    logic [63:0] symbols_b;
    logic [63:0] symbols_c;
    logic [63:0] symbols_d;
    logic        frame_done;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FILL,
    ST_RESP
  } state_t;

  // Pack one line symbol: level1, dur1, level0, dur0 from the top down
  function automatic logic [31:0] make_word(input logic lv0, input logic [TICK_W-1:0] d0,
                                            input logic lv1, input logic [TICK_W-1:0] d1);
    make_word = {lv1, d1, lv0, d0};
  endfunction

endpackage

>>> sv/rlsfe_ifs.sv
// ----------------------------------------------------------------------------
// rlsfe channel interfaces
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
interface rlsfe_in_if;
  import rlsfe_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rlsfe_out_if;
  import rlsfe_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/rgb_led_strip_frame_encoder.sv
// ----------------------------------------------------------------------------
// rgb_led_strip_frame_encoder: LED grid pixel store and line-symbol encoder
// Holds a green-red-blue pixel store, serves pixel writes/reads, fills the
// grid and encodes a stored byte as eight timed line symbols or a latch.
// ----------------------------------------------------------------------------
// Flow: an item passes EXEC, READ for a registered store read (pixel reads,
//   encoded bytes) or FILL (one store write per active pixel), then RESP,
//   which loads the result into the output register once it is free.
//   Items run one at a time through the single-port store sequence accept,
//   access, respond.
// Reset: a clearing pass writes zero to all 1024 store entries, one per
//   cycle, before the first item is taken; registers reset at once.
module rgb_led_strip_frame_encoder (
  input  logic                               clk,
  input  logic                               rst_n,
  rlsfe_in_if.sink                           in_ch,
  rlsfe_out_if.source                        out_ch,
  input  logic                               cfg_we,
  input  logic [rlsfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlsfe_pkg::CFG_DW-1:0]       cfg_data
);
  import rlsfe_pkg::*;

  // Configuration registers
  logic [7:0]        grid_width_r;
  logic [7:0]        grid_height_r;
  logic [TICK_W-1:0] zero_high_r;
  logic [TICK_W-1:0] zero_low_r;
  logic [TICK_W-1:0] one_high_r;
  logic [TICK_W-1:0] one_low_r;
  logic [TICK_W-1:0] latch_r;

  // Control and datapath state
  state_t            state_r, state_nxt;
  in_item_t          req_r;
  logic [PIX_CW-1:0] cnt_r, cnt_nxt;
  logic [PIX_CW-1:0] pix_r, pix_nxt;
  logic [1:0]        lane_r, lane_nxt;
  out_item_t         res_r, res_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic              out_load;

  // Pixel store and its single port
  logic [COLOR_W-1:0] mem [MAX_PIXELS];
  logic [COLOR_W-1:0] rdata_r;
  logic               mem_we;
  logic               mem_re;
  logic [PIX_AW-1:0]  mem_addr;
  logic [COLOR_W-1:0] mem_wdata;

  // Derived geometry
  logic [15:0]        area;
  logic [PIX_CW-1:0]  npix;
  logic [16:0]        xy_pix;
  logic               xy_ok;
  logic               idx_ok;
  logic [COLOR_W-1:0] req_color;
  logic [PIX_CW-1:0]  enc_pos;
  logic [1:0]         enc_lane;
  logic [7:0]         enc_byte;
  logic [31:0]        zero_word;
  logic [31:0]        one_word;
  logic [7:0][31:0]   words;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
      zero_high_r   <= ZERO_HIGH_RST;
      zero_low_r    <= ZERO_LOW_RST;
      one_high_r    <= ONE_HIGH_RST;
      one_low_r     <= ONE_LOW_RST;
      latch_r       <= LATCH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data[7:0];
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data[7:0];
        CFG_ZERO_HIGH:   zero_high_r   <= cfg_data;
        CFG_ZERO_LOW:    zero_low_r    <= cfg_data;
        CFG_ONE_HIGH:    one_high_r    <= cfg_data;
        CFG_ONE_LOW:     one_low_r     <= cfg_data;
        CFG_LATCH:       latch_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Compute active pixel count and the addressed pixel
  assign area   = 16'(grid_width_r) * 16'(grid_height_r);
  assign npix   = (area > 16'(MAX_PIXELS)) ? PIX_CW'(MAX_PIXELS) : area[PIX_CW-1:0];
  assign xy_pix = 17'(16'(req_r.row_y) * 16'(grid_width_r)) + 17'(req_r.col_x);
  assign xy_ok  = (req_r.col_x < grid_width_r) && (req_r.row_y < grid_height_r) &&
                  (xy_pix < 17'(npix));
  assign idx_ok = 17'(req_r.linear_index) < 17'(npix);
  assign req_color = {req_r.green_in, req_r.red_in, req_r.blue_in};

  // Pick the encode start position
  assign enc_pos  = req_r.first_chunk ? '0 : pix_r;
  assign enc_lane = req_r.first_chunk ? LANE_GREEN : lane_r;

  // Select the byte to send and build its symbols, MSB first
  always_comb begin
    case (lane_r)
      LANE_GREEN: enc_byte = rdata_r[23:16];
      LANE_RED:   enc_byte = rdata_r[15:8];
      default:    enc_byte = rdata_r[7:0];
    endcase
  end

  assign zero_word = make_word(1'b1, zero_high_r, 1'b0, zero_low_r);
  assign one_word  = make_word(1'b1, one_high_r, 1'b0, one_low_r);

  always_comb begin
    for (int i = 0; i < SYM_PER_BYTE; i++) begin
      words[i] = enc_byte[SYM_PER_BYTE-1-i] ? one_word : zero_word;
    end
  end

  // Next state, store port and result staging
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pix_nxt   = pix_r;
    lane_nxt  = lane_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cnt_r[PIX_AW-1:0];
    mem_wdata = '0;
    out_load  = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_r == PIX_CW'(MAX_PIXELS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_nxt   = '0;
        state_nxt = ST_RESP;
        case (req_r.req_type) inside
          REQ_WRITE_XY, REQ_READ_XY: begin
            mem_addr  = xy_pix[PIX_AW-1:0];
            mem_wdata = req_color;
            if (!xy_ok) begin
              res_nxt.status = STS_OUTSIDE;
            end else if (req_r.req_type == REQ_WRITE_XY) begin
              mem_we = 1'b1;
            end else begin
              mem_re    = 1'b1;
              state_nxt = ST_READ;
            end
          end
          REQ_WRITE_IDX, REQ_READ_IDX: begin
            mem_addr  = req_r.linear_index[PIX_AW-1:0];
            mem_wdata = req_color;
            if (!idx_ok) begin
              res_nxt.status = STS_OUTSIDE;
            end else if (req_r.req_type == REQ_WRITE_IDX) begin
              mem_we = 1'b1;
            end else begin
              mem_re    = 1'b1;
              state_nxt = ST_READ;
            end
          end
          REQ_FILL: begin
            cnt_nxt = '0;
            if (npix != '0) begin
              state_nxt = ST_FILL;
            end
          end
          REQ_ENCODE: begin
            if (req_r.room < ROOM_MIN) begin
              res_nxt.status = STS_NO_ROOM;
            end else begin
              pix_nxt  = enc_pos;
              lane_nxt = enc_lane;
              if (enc_pos < npix) begin
                mem_addr  = enc_pos[PIX_AW-1:0];
                mem_re    = 1'b1;
                state_nxt = ST_READ;
              end else begin
                res_nxt.symbol_count    = CNT_LATCH;
                res_nxt.symbols_a[31:0] = make_word(1'b0, latch_r, 1'b0, latch_r);
                res_nxt.frame_done      = 1'b1;
              end
            end
          end
          default: res_nxt.status = STS_OUTSIDE;
        endcase
      end

      ST_READ: begin
        state_nxt = ST_RESP;
        if (req_r.req_type == REQ_ENCODE) begin
          res_nxt.symbol_count = CNT_BYTE;
          res_nxt.symbols_a    = {words[1], words[0]};
          res_nxt.symbols_b    = {words[3], words[2]};
          res_nxt.symbols_c    = {words[5], words[4]};
          res_nxt.symbols_d    = {words[7], words[6]};
          // Advance to the next byte lane, then the next pixel
          if (lane_r == LANE_BLUE) begin
            lane_nxt = LANE_GREEN;
            pix_nxt  = pix_r + 1'b1;
          end else begin
            lane_nxt = lane_r + 1'b1;
          end
        end else begin
          res_nxt.green_out = rdata_r[23:16];
          res_nxt.red_out   = rdata_r[15:8];
          res_nxt.blue_out  = rdata_r[7:0];
        end
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = req_color;
        if (cnt_r == npix - 1'b1) begin
          state_nxt = ST_RESP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_RESP: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      pix_r       <= '0;
      lane_r      <= LANE_GREEN;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pix_r   <= pix_nxt;
      lane_r  <= lane_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold request and result payloads
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_ch.valid && in_ch.ready) begin
      req_r <= in_ch.data;
    end
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  // Pixel store: one access per cycle, registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // Assertions
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ch.ready)
    else $error("item taken during store clearing pass");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_EXEC))
    else $error("accepted item not executed next cycle");

  a_store_port_single: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("store read and write in the same cycle");

  a_pix_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pix_r <= PIX_CW'(MAX_PIXELS))
    else $error("encode position beyond store");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> (cnt_r < npix))
    else $error("fill counter beyond active pixels");

endmodule

>>> tb/tb_rgb_led_strip_frame_encoder.sv
// ----------------------------------------------------------------------------
// tb_rgb_led_strip_frame_encoder: self-checking bench of the LED frame encoder
// Streams pixel writes, reads, fills and encode requests through the request
// channel under several grid and timing settings. A predictor of its own
// follows the pixel store and the encode position, and every result item is
// checked field by field against the oldest prediction. The sender runs in
// random bursts and gaps, and the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb_rgb_led_strip_frame_encoder;
  import rlsfe_pkg::*;

  // Request codes the block does not define
  localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

  // Cycles without any accepted item before the run is given up
  localparam int unsigned IDLE_LIMIT = 6000;
  // Cycles to let pass after the last result before a register write or the end
  localparam int unsigned SETTLE_CYCLES = 8;
  // Mismatch lines printed at most
  localparam int unsigned MAX_REPORTS = 30;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  rlsfe_in_if  in_if ();
  rlsfe_out_if out_if ();

  rgb_led_strip_frame_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: pixel store, encode position and register copies
  logic [COLOR_W-1:0] pixel_mem [MAX_PIXELS];
  int unsigned byte_pos;
  logic [7:0] grid_w;
  logic [7:0] grid_h;
  logic [TICK_W-1:0] zero_high;
  logic [TICK_W-1:0] zero_low;
  logic [TICK_W-1:0] one_high;
  logic [TICK_W-1:0] one_low;
  logic [TICK_W-1:0] latch_len;

  in_item_t pending_requests[$];
  out_item_t predicted_results[$];
  out_item_t want;

  int unsigned requests_queued;
  int unsigned requests_taken;
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_cycle;
  int unsigned stall_mode;

  // Clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Active pixels: the grid, clipped to the store
  function automatic int unsigned grid_pixels();
    int unsigned n;
    n = 32'(grid_w) * 32'(grid_h);
    return (n > MAX_PIXELS) ? MAX_PIXELS : n;
  endfunction

  // Predict the result item of one request and advance the store state
  function automatic out_item_t encoder_response(in_item_t it);
    out_item_t r;
    logic [255:0] syms;
    logic ok;
    int unsigned npix;
    int unsigned pix;
    logic [COLOR_W-1:0] word;
    logic [7:0] b;
    r = '0;
    syms = '0;
    npix = grid_pixels();
    case (it.req_type)
      REQ_WRITE_XY, REQ_READ_XY, REQ_WRITE_IDX, REQ_READ_IDX: begin
        if (it.req_type == REQ_WRITE_XY || it.req_type == REQ_READ_XY) begin
          ok = (it.col_x < grid_w) && (it.row_y < grid_h);
          pix = 32'(it.row_y) * 32'(grid_w) + 32'(it.col_x);
        end else begin
          ok = 1'b1;
          pix = 32'(it.linear_index);
        end
        ok = ok && (pix < npix);
        if (!ok) begin
          r.status = STS_OUTSIDE;
        end else if (it.req_type == REQ_WRITE_XY || it.req_type == REQ_WRITE_IDX) begin
          pixel_mem[pix] = {it.green_in, it.red_in, it.blue_in};
        end else begin
          r.green_out = pixel_mem[pix][23:16];
          r.red_out   = pixel_mem[pix][15:8];
          r.blue_out  = pixel_mem[pix][7:0];
        end
      end
      REQ_FILL: begin
        for (int i = 0; i < npix; i++) pixel_mem[i] = {it.green_in, it.red_in, it.blue_in};
      end
      REQ_ENCODE: begin
        if (it.room < ROOM_MIN) begin
          r.status = STS_NO_ROOM;
        end else begin
          if (it.first_chunk) byte_pos = 0;
          if (byte_pos < npix * 3) begin
            word = pixel_mem[byte_pos / 3];
            case (2'(byte_pos % 3))
              LANE_GREEN: b = word[23:16];
              LANE_RED:   b = word[15:8];
              default:    b = word[7:0];
            endcase
            // MSB first; high part then low part of each bit
            for (int i = 0; i < SYM_PER_BYTE; i++) begin
              syms[32*i +: 32] = b[7-i] ? {1'b0, one_low, 1'b1, one_high}
                                        : {1'b0, zero_low, 1'b1, zero_high};
            end
            byte_pos++;
            r.symbol_count = CNT_BYTE;
          end else begin
            syms[31:0] = {1'b0, latch_len, 1'b0, latch_len};
            r.symbol_count = CNT_LATCH;
            r.frame_done = 1'b1;
          end
        end
      end
      default: r.status = STS_OUTSIDE;
    endcase
    r.symbols_a = syms[63:0];
    r.symbols_b = syms[127:64];
    r.symbols_c = syms[191:128];
    r.symbols_d = syms[255:192];
    return r;
  endfunction

  function automatic void compare_field(string field, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp_v, act_v);
    end
  endfunction

  function automatic in_item_t mk_req(logic [2:0] kind, logic [7:0] x, logic [7:0] y,
                                      logic [15:0] idx, logic [23:0] rgb, logic first,
                                      logic [ROOM_W-1:0] room);
    in_item_t it;
    it.req_type     = kind;
    it.col_x        = x;
    it.row_y        = y;
    it.linear_index = idx;
    it.red_in       = rgb[23:16];
    it.green_in     = rgb[15:8];
    it.blue_in      = rgb[7:0];
    it.first_chunk  = first;
    it.room         = room;
    return it;
  endfunction

  function automatic in_item_t random_fields();
    in_item_t it;
    it.req_type     = 3'($urandom_range(0, 7));
    it.col_x        = 8'($urandom);
    it.row_y        = 8'($urandom);
    it.linear_index = 16'($urandom);
    it.red_in       = 8'($urandom);
    it.green_in     = 8'($urandom);
    it.blue_in      = 8'($urandom);
    it.first_chunk  = 1'($urandom);
    it.room         = ROOM_W'($urandom);
    return it;
  endfunction

  task automatic queue_request(in_item_t it);
    pending_requests.push_back(it);
    requests_queued++;
  endtask

  // Write one register and update the predictor's copy
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DW-1:0];
    case (idx)
      CFG_GRID_WIDTH:  grid_w    = val[7:0];
      CFG_GRID_HEIGHT: grid_h    = val[7:0];
      CFG_ZERO_HIGH:   zero_high = val[TICK_W-1:0];
      CFG_ZERO_LOW:    zero_low  = val[TICK_W-1:0];
      CFG_ONE_HIGH:    one_high  = val[TICK_W-1:0];
      CFG_ONE_LOW:     one_low   = val[TICK_W-1:0];
      default:         latch_len = val[TICK_W-1:0];
    endcase
  endtask

  task automatic set_grid(int unsigned w, int unsigned h, int unsigned zh, int unsigned zl,
                          int unsigned oh, int unsigned ol, int unsigned lt);
    write_reg(CFG_GRID_WIDTH, w);
    write_reg(CFG_GRID_HEIGHT, h);
    write_reg(CFG_ZERO_HIGH, zh);
    write_reg(CFG_ZERO_LOW, zl);
    write_reg(CFG_ONE_HIGH, oh);
    write_reg(CFG_ONE_LOW, ol);
    write_reg(CFG_LATCH, lt);
    @(posedge clk);
    cfg_we <= 1'b0;
    // hand stimulus over away from the clock edge
    @(negedge clk);
  endtask

  // Wait for every request to be taken and every result to arrive, then settle
  task automatic wait_drained();
    while (requests_taken != requests_queued || predicted_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random traffic: mostly encode streams and in-grid accesses, some noise
  task automatic queue_random(int unsigned n);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned npix;
    in_item_t it;
    sent = 0;
    npix = grid_pixels();
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // encode stream, long enough to pass the frame end on small grids
        len = npix * 3 + 3;
        if (len > 48) len = 48;
        len = $urandom_range(1, len);
        for (int k = 0; k < len; k++) begin
          it = random_fields();
          it.req_type = REQ_ENCODE;
          it.first_chunk = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 24) == 0);
          it.room = ($urandom_range(0, 9) == 0) ? ROOM_W'($urandom_range(0, 7))
                                                : ROOM_W'($urandom_range(8, 1023));
          queue_request(it);
          sent++;
        end
      end else begin
        it = random_fields();
        if (pick < 55)      it.req_type = REQ_WRITE_XY;
        else if (pick < 65) it.req_type = REQ_WRITE_IDX;
        else if (pick < 78) it.req_type = REQ_READ_XY;
        else if (pick < 88) it.req_type = REQ_READ_IDX;
        else if (pick < 92) it.req_type = REQ_FILL;
        else if (pick < 95) it.req_type = $urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
        // keep most positions inside the grid, some right at its edge
        if ($urandom_range(0, 4) != 0) begin
          it.col_x = 8'($urandom_range(0, grid_w - 1));
          it.row_y = 8'($urandom_range(0, grid_h - 1));
        end
        case ($urandom_range(0, 7))
          0:       it.linear_index = 16'(npix + $urandom_range(0, 2));
          1:       ;
          default: it.linear_index = 16'($urandom_range(0, npix - 1));
        endcase
        queue_request(it);
        sent++;
      end
    end
  endtask

  // Driver: feed requests in bursts with random gaps, predict at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predicted_results.push_back(encoder_response(in_if.data));
        requests_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.data  <= pending_requests.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(30, 80);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = $urandom_range(1, 10);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: switch between random ready modes
  always @(posedge clk) begin
    if (stall_cycle % 48 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_if.ready <= 1'b1;
      1:       out_if.ready <= 1'($urandom_range(0, 1));
      2:       out_if.ready <= (stall_cycle % 4 == 0);
      default: out_if.ready <= stall_cycle[3];
    endcase
    stall_cycle++;
  end

  // Monitor: check each result item against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result item with none expected: expected none, actual %h",
                   $time, out_if.data);
      end else begin
        want = predicted_results.pop_front();
        compare_field("status", 64'(want.status), 64'(out_if.data.status));
        compare_field("red_out", 64'(want.red_out), 64'(out_if.data.red_out));
        compare_field("green_out", 64'(want.green_out), 64'(out_if.data.green_out));
        compare_field("blue_out", 64'(want.blue_out), 64'(out_if.data.blue_out));
        compare_field("symbol_count", 64'(want.symbol_count), 64'(out_if.data.symbol_count));
        compare_field("symbols_a", want.symbols_a, out_if.data.symbols_a);
        compare_field("symbols_b", want.symbols_b, out_if.data.symbols_b);
        compare_field("symbols_c", want.symbols_c, out_if.data.symbols_c);
        compare_field("symbols_d", want.symbols_d, out_if.data.symbols_d);
        compare_field("frame_done", 64'(want.frame_done), 64'(out_if.data.frame_done));
      end
    end
  end

  // Watchdog: give up when no item moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("** rgb_led_strip_frame_encoder: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    // Drive every input to a known value and mirror the reset state
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    out_if.ready = 1'b0;
    for (int i = 0; i < MAX_PIXELS; i++) pixel_mem[i] = '0;
    byte_pos  = 0;
    grid_w    = GRID_WIDTH_RST;
    grid_h    = GRID_HEIGHT_RST;
    zero_high = ZERO_HIGH_RST;
    zero_low  = ZERO_LOW_RST;
    one_high  = ONE_HIGH_RST;
    one_low   = ONE_LOW_RST;
    latch_len = LATCH_RST;
    requests_queued = 0;
    requests_taken  = 0;
    mismatches  = 0;
    idle_cycles = 0;
    burst_left  = 1;
    gap_left    = 0;
    stall_cycle = 0;
    stall_mode  = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values of the registers: 8x8 grid; corners, edges, reads of a clear store
    queue_request(mk_req(REQ_READ_XY, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b0, 10'd0));
    queue_request(mk_req(REQ_WRITE_XY, 8'd7, 8'd7, 16'd0, 24'hffffff, 1'b0, 10'd0));
    queue_request(mk_req(REQ_READ_XY, 8'd7, 8'd7, 16'hffff, 24'h000000, 1'b1, 10'h3ff));
    queue_request(mk_req(REQ_WRITE_XY, 8'd8, 8'd0, 16'd0, 24'h5a5a5a, 1'b0, 10'd0));
    queue_request(mk_req(REQ_READ_XY, 8'd255, 8'd255, 16'd0, 24'h000000, 1'b0, 10'd0));
    queue_request(mk_req(REQ_WRITE_IDX, 8'd0, 8'd0, 16'd0, 24'h123456, 1'b0, 10'd0));
    queue_request(mk_req(REQ_READ_IDX, 8'd0, 8'd0, 16'd63, 24'h000000, 1'b0, 10'd0));
    queue_request(mk_req(REQ_READ_IDX, 8'd0, 8'd0, 16'd64, 24'h000000, 1'b0, 10'd0));
    queue_request(mk_req(REQ_WRITE_IDX, 8'd0, 8'd0, 16'hffff, 24'hffffff, 1'b0, 10'd0));
    queue_request(mk_req(REQ_ENCODE, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b1, 10'd7));
    queue_request(mk_req(REQ_ENCODE, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b1, 10'd8));
    queue_request(mk_req(REQ_ENCODE, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b0, 10'h3ff));
    queue_request(mk_req(REQ_UNUSED_6, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b0, 10'd0));
    queue_request(mk_req(REQ_UNUSED_7, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b0, 10'd0));
    queue_request(mk_req(REQ_FILL, 8'd0, 8'd0, 16'd0, 24'hc33c81, 1'b0, 10'd0));
    queue_request(mk_req(REQ_READ_XY, 8'd3, 8'd3, 16'd0, 24'h000000, 1'b0, 10'd0));
    queue_request(mk_req(REQ_FILL, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b0, 10'd0));
    queue_request(mk_req(REQ_READ_IDX, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b0, 10'd0));
    wait_drained();

    // Single pixel with extreme timings: run past the frame end, then restart
    set_grid(1, 1, 0, 32767, 32767, 0, 32767);
    queue_request(mk_req(REQ_WRITE_IDX, 8'd0, 8'd0, 16'd0, 24'h815aff, 1'b0, 10'd0));
    queue_request(mk_req(REQ_ENCODE, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b1, 10'd8));
    queue_request(mk_req(REQ_ENCODE, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b0, 10'd9));
    queue_request(mk_req(REQ_ENCODE, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b0, 10'd8));
    queue_request(mk_req(REQ_ENCODE, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b0, 10'd8));
    queue_request(mk_req(REQ_ENCODE, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b0, 10'h3ff));
    queue_request(mk_req(REQ_ENCODE, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b1, 10'd0));
    queue_request(mk_req(REQ_ENCODE, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b1, 10'd8));
    wait_drained();

    // Zero height: every access outside, fill empty, frame ends at once
    set_grid(5, 0, 40, 85, 80, 45, 250);
    queue_request(mk_req(REQ_WRITE_XY, 8'd0, 8'd0, 16'd0, 24'h010203, 1'b0, 10'd0));
    queue_request(mk_req(REQ_READ_IDX, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b0, 10'd0));
    queue_request(mk_req(REQ_FILL, 8'd0, 8'd0, 16'd0, 24'hffffff, 1'b0, 10'd0));
    queue_request(mk_req(REQ_ENCODE, 8'd0, 8'd0, 16'd0, 24'h000000, 1'b1, 10'd8));
    wait_drained();

    // Random phases across grid shapes and timing settings
    set_grid(2, 3, $urandom_range(0, 32767), $urandom_range(0, 32767),
             $urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 32767));
    queue_random(260);
    wait_drained();

    set_grid(8, 8, 40, 85, 80, 45, 250);
    queue_random(220);
    wait_drained();

    // Grid larger than the store
    set_grid(255, 255, 32767, 32767, 32767, 32767, 32767);
    queue_random(200);
    wait_drained();

    set_grid(1, 4, 0, 0, 0, 0, 0);
    queue_random(220);
    wait_drained();

    set_grid(255, 4, $urandom_range(0, 32767), $urandom_range(0, 32767),
             $urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 32767));
    queue_random(180);
    wait_drained();

    set_grid(16, 16, $urandom_range(0, 32767), $urandom_range(0, 32767),
             $urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 32767));
    queue_random(220);
    wait_drained();

    set_grid(3, 5, $urandom_range(0, 32767), $urandom_range(0, 32767),
             $urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 32767));
    queue_random(260);
    wait_drained();

    set_grid(1, 255, $urandom_range(0, 32767), $urandom_range(0, 32767),
             $urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 32767));
    queue_random(200);
    wait_drained();

    set_grid(1, 1, $urandom_range(0, 32767), $urandom_range(0, 32767),
             $urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 32767));
    queue_random(100);
    wait_drained();

    if (mismatches == 0)
      $display("** rgb_led_strip_frame_encoder: PASSED **");
    else
      $display("** rgb_led_strip_frame_encoder: FAILED **");
    $finish;
  end

endmodule
